// ===== design/fwq_pkg.sv =====
package fwq_pkg;

    localparam int TABLE_ENTRIES_DEF = 32;
    localparam int COUNT_W           = 6;

    localparam logic [1:0] CMD_WAIT     = 2'd0;
    localparam logic [1:0] CMD_WAKE     = 2'd1;
    localparam logic [1:0] CMD_WAKE_ALL = 2'd2;
    localparam logic [1:0] CMD_ABORT    = 2'd3;

    localparam logic [2:0] KIND_QUEUED      = 3'd0;
    localparam logic [2:0] KIND_TRY_AGAIN   = 3'd1;
    localparam logic [2:0] KIND_FULL        = 3'd2;
    localparam logic [2:0] KIND_WOKEN       = 3'd3;
    localparam logic [2:0] KIND_DONE        = 3'd4;
    localparam logic [2:0] KIND_INTERRUPTED = 3'd5;
    localparam logic [2:0] KIND_NOT_FOUND   = 3'd6;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] process_id;
        logic [15:0] thread_id;
        logic [47:0] word_address;
        logic [31:0] expected_value;
        logic [31:0] memory_value;
        logic [15:0] wake_limit;
    } in_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [15:0]        woken_thread;
        logic [COUNT_W-1:0] woken_count;
        logic               last;
    } out_t;

    typedef struct packed {
        logic       load_req;
        logic       calc_match;
        logic       do_append;
        logic       do_remove;
        logic       emit;
        logic [2:0] emit_kind;
        logic       emit_last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_wait;
        logic is_abort;
        logic is_limited;
        logic value_match;
        logic full;
        logic any_match;
        logic limit_hit;
        logic out_free;
    } dp_status_t;

endpackage

// ===== design/fwq_ctrl.sv =====
module fwq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fwq_pkg::dp_status_t st,
    output fwq_pkg::ctrl_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MATCH = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_MATCH;
                end
            end
            S_MATCH:
            begin
                if (st.is_wait)
                begin
                    if (st.out_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_last = 1'b1;
                        if (!st.value_match)
                            cmd.emit_kind = fwq_pkg::KIND_TRY_AGAIN;
                        else if (st.full)
                            cmd.emit_kind = fwq_pkg::KIND_FULL;
                        else
                        begin
                            cmd.emit_kind = fwq_pkg::KIND_QUEUED;
                            cmd.do_append = 1'b1;
                        end
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.calc_match = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (st.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (st.is_abort)
                    begin
                        cmd.emit_last = 1'b1;
                        state_next    = S_IDLE;
                        if (st.any_match)
                        begin
                            cmd.do_remove = 1'b1;
                            cmd.emit_kind = fwq_pkg::KIND_INTERRUPTED;
                        end
                        else
                            cmd.emit_kind = fwq_pkg::KIND_NOT_FOUND;
                    end
                    else if (!st.any_match || (st.is_limited && st.limit_hit))
                    begin
                        cmd.emit_kind = fwq_pkg::KIND_DONE;
                        cmd.emit_last = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        cmd.emit_kind = fwq_pkg::KIND_WOKEN;
                        cmd.do_remove = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== design/fwq_datapath.sv =====
module fwq_datapath #(
    parameter int TABLE_ENTRIES = fwq_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  fwq_pkg::in_t        in_data,
    input  fwq_pkg::ctrl_cmd_t  cmd,
    output fwq_pkg::dp_status_t st,
    output logic                out_valid,
    input  logic                out_ready,
    output fwq_pkg::out_t       out_data
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    logic [15:0] pid_reg  [TABLE_ENTRIES];
    logic [15:0] tid_reg  [TABLE_ENTRIES];
    logic [47:0] addr_reg [TABLE_ENTRIES];

    logic [CNT_W-1:0]           occ_reg;
    logic [TABLE_ENTRIES-1:0]   match_reg;
    logic [TABLE_ENTRIES-1:0]   match_next;
    logic [fwq_pkg::COUNT_W-1:0] woken_reg;
    fwq_pkg::in_t               req_reg;
    logic                       out_valid_reg;
    fwq_pkg::out_t              out_reg;
    fwq_pkg::out_t              out_next;

    logic [IDX_W-1:0] hit_idx;
    logic             any_hit;

    // oldest pending match
    always_comb
    begin
        hit_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (match_reg[i])
                hit_idx = IDX_W'(i);
        end
        any_hit = |match_reg;
    end

    always_comb
    begin
        match_next = match_reg;
        if (cmd.calc_match)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                match_next[i] = (CNT_W'(i) < occ_reg)
                             && (pid_reg[i] == req_reg.process_id)
                             && (addr_reg[i] == req_reg.word_address)
                             && ((req_reg.command != fwq_pkg::CMD_ABORT)
                                 || (tid_reg[i] == req_reg.thread_id));
            end
        end
        else if (cmd.do_remove)
        begin
            for (int i = 0; i < TABLE_ENTRIES - 1; i++)
            begin
                if (i >= int'(hit_idx))
                    match_next[i] = match_reg[i + 1];
            end
            match_next[TABLE_ENTRIES - 1] = 1'b0;
        end
    end

    assign st.is_wait     = (req_reg.command == fwq_pkg::CMD_WAIT);
    assign st.is_abort    = (req_reg.command == fwq_pkg::CMD_ABORT);
    assign st.is_limited  = (req_reg.command == fwq_pkg::CMD_WAKE);
    assign st.value_match = (req_reg.memory_value == req_reg.expected_value);
    assign st.full        = (occ_reg >= CNT_W'(TABLE_ENTRIES));
    assign st.any_match   = any_hit;
    assign st.limit_hit   = ({{(16 - fwq_pkg::COUNT_W){1'b0}}, woken_reg} >= req_reg.wake_limit);
    assign st.out_free    = !out_valid_reg || out_ready;

    always_comb
    begin
        out_next.kind         = cmd.emit_kind;
        out_next.last         = cmd.emit_last;
        out_next.woken_thread = '0;
        out_next.woken_count  = '0;
        if (cmd.emit_kind == fwq_pkg::KIND_WOKEN)
            out_next.woken_thread = tid_reg[hit_idx];
        else if (cmd.emit_kind == fwq_pkg::KIND_INTERRUPTED)
            out_next.woken_thread = req_reg.thread_id;
        if (cmd.emit_kind == fwq_pkg::KIND_DONE)
            out_next.woken_count = woken_reg;
    end

    // entry payload, request, match vector and result register, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
            req_reg <= in_data;
        match_reg <= match_next;
        if (cmd.emit)
            out_reg <= out_next;
        if (cmd.do_append)
        begin
            pid_reg[occ_reg[IDX_W-1:0]]  <= req_reg.process_id;
            tid_reg[occ_reg[IDX_W-1:0]]  <= req_reg.thread_id;
            addr_reg[occ_reg[IDX_W-1:0]] <= req_reg.word_address;
        end
        else if (cmd.do_remove)
        begin
            for (int i = 0; i < TABLE_ENTRIES - 1; i++)
            begin
                if (i >= int'(hit_idx))
                begin
                    pid_reg[i]  <= pid_reg[i + 1];
                    tid_reg[i]  <= tid_reg[i + 1];
                    addr_reg[i] <= addr_reg[i + 1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            woken_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.do_append)
                occ_reg <= occ_reg + 1'b1;
            else if (cmd.do_remove)
                occ_reg <= occ_reg - 1'b1;
            if (cmd.load_req)
                woken_reg <= '0;
            else if (cmd.do_remove)
                woken_reg <= woken_reg + 1'b1;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== design/futex_wait_queue_table_top.sv =====
// channel | direction | handshake            | payload
// request | in        | in_valid / in_ready  | in_data  (fwq_pkg::in_t)
// result  | out       | out_valid / out_ready | out_data (fwq_pkg::out_t)
//
// a wait goes from idle through the match state to the result register; an abort also passes the scan state
// a wake passes the match and scan states and gives one result per cycle while the result register is free,
// paced by the remove-and-close-up step on the entry registers
// one request is in flight at a time; in_ready is high only when idle
// a stalled result register holds the controller in place
// reset clears occupancy and the controller, entries need no clearing
module futex_wait_queue_table_top #(
    parameter int TABLE_ENTRIES = fwq_pkg::TABLE_ENTRIES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  fwq_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output fwq_pkg::out_t out_data
);

    fwq_pkg::ctrl_cmd_t  cmd;
    fwq_pkg::dp_status_t st;

    fwq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    fwq_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .st        (st),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== design/fwq_checker.sv =====
module fwq_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input fwq_pkg::out_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped or changed while stalled");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while another is in flight");

    a_nonlast_woken: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last |-> out_data.kind == fwq_pkg::KIND_WOKEN)
        else $error("non-final result that is not a woken result");

    a_thread_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind != fwq_pkg::KIND_WOKEN
        && out_data.kind != fwq_pkg::KIND_INTERRUPTED |-> out_data.woken_thread == 16'd0)
        else $error("thread id on a result that carries none");

    a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind != fwq_pkg::KIND_DONE |-> out_data.woken_count == '0)
        else $error("count on a result that is not wake done");

endmodule

bind futex_wait_queue_table_top fwq_checker u_fwq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
